[rtl/ubsc_pkg.sv]
// Shared types, codes and the port name table for the byte stream classifier.
// Used by every module in rtl/.
package ubsc_pkg;

  localparam int WinDepth  = 7;
  localparam int TableSize = 42;
  localparam int MaxSpan   = 6;

  localparam logic [2:0] OP_DATA   = 3'd0;
  localparam logic [2:0] OP_FLUSH  = 3'd1;
  localparam logic [2:0] OP_BADASC = 3'd2;
  localparam logic [2:0] OP_BADBIN = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Tally indexes.
  localparam logic [3:0] T_PRINT   = 4'd0;
  localparam logic [3:0] T_BIN     = 4'd1;
  localparam logic [3:0] T_LF      = 4'd2;
  localparam logic [3:0] T_CR      = 4'd3;
  localparam logic [3:0] T_OK      = 4'd4;
  localparam logic [3:0] T_PORT    = 4'd5;
  localparam logic [3:0] T_BADPORT = 4'd6;
  localparam logic [3:0] T_PBYTES  = 4'd7;
  localparam logic [3:0] T_BADASC  = 4'd8;
  localparam logic [3:0] T_BADBIN  = 4'd9;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] printable_bytes;
    logic [31:0] binary_bytes;
    logic [31:0] line_feeds;
    logic [31:0] carriage_returns;
    logic [31:0] ok_prompts;
    logic [31:0] port_prompts;
    logic [31:0] bad_port_prompts;
    logic [31:0] port_prompt_bytes;
    logic [31:0] bad_ascii_messages;
    logic [31:0] bad_binary_messages;
    logic [2:0]  pending_bytes;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;   // capture op/byte, append data byte
    logic       step;   // make one decision at window head
    logic       clear;
    logic       flush;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic can_step;     // head decision is available
  } dp_sts_t;

  typedef logic [47:0] name_t;  // six bytes, byte 0 in [7:0], zero padded

  function automatic name_t name_entry(input logic [5:0] k);
    name_t n;
    n = '0;
    unique case (k)
      6'd0:  n = {16'h0, "1MOC"};
      6'd1:  n = {16'h0, "2MOC"};
      6'd2:  n = {16'h0, "3MOC"};
      6'd3:  n = {16'h0, "4MOC"};
      6'd4:  n = {16'h0, "5MOC"};
      6'd5:  n = {16'h0, "6MOC"};
      6'd6:  n = {16'h0, "7MOC"};
      6'd7:  n = {16'h0, "8MOC"};
      6'd8:  n = {16'h0, "9MOC"};
      6'd9:  n = {8'h0, "01MOC"};
      6'd10: n = {8'h0, "1MOCC"};
      6'd11: n = {8'h0, "2MOCC"};
      6'd12: n = {8'h0, "3MOCC"};
      6'd13: n = {8'h0, "4MOCC"};
      6'd14: n = {8'h0, "5MOCC"};
      6'd15: n = {8'h0, "6MOCC"};
      6'd16: n = {8'h0, "7MOCC"};
      6'd17: n = {8'h0, "8MOCC"};
      6'd18: n = {8'h0, "1MOCI"};
      6'd19: n = {8'h0, "2MOCI"};
      6'd20: n = {8'h0, "3MOCI"};
      6'd21: n = {8'h0, "4MOCI"};
      6'd22: n = {8'h0, "5MOCI"};
      6'd23: n = {8'h0, "6MOCI"};
      6'd24: n = {8'h0, "7MOCI"};
      6'd25: n = {8'h0, "1MOCS"};
      6'd26: n = {8'h0, "2MOCS"};
      6'd27: n = {8'h0, "3MOCS"};
      6'd28: n = {8'h0, "4MOCS"};
      6'd29: n = {8'h0, "1MOCN"};
      6'd30: n = {8'h0, "2MOCN"};
      6'd31: n = {8'h0, "3MOCN"};
      6'd32: n = {16'h0, "1BSU"};
      6'd33: n = {16'h0, "2BSU"};
      6'd34: n = {16'h0, "3BSU"};
      6'd35: n = {8'h0, "1MOCX"};
      6'd36: n = {8'h0, "2MOCX"};
      6'd37: n = {8'h0, "3MOCX"};
      6'd38: n = {24'h0, "KCA"};
      6'd39: n = {16'h0, "ELIF"};
      6'd40: n = {24'h0, "XUA"};
      6'd41: n = {8'h0, "1MOCW"};
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

[rtl/unknown_byte_stream_classifier.sv]
// Top level of the byte stream classifier: controller plus datapath.
// Depends on ubsc_pkg, ubsc_ctrl, ubsc_datapath.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_word_t  | in_valid / in_stall
//   out     | output    | out_word_t | out_valid / out_stall
//
// A data or flush word is loaded, then the window is drained one decision per
// cycle until no decision is left, then the result is shown. Other ops load and
// show the result.
// rst is synchronous and clears the window and all tallies.
// in_stall is high while a word is in work or its result is waiting.
// The result holds while out_stall is high.
module unknown_byte_stream_classifier
  import ubsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy;
  logic    in_fire;
  logic    out_fire;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_fire = out_valid && !out_stall;

  ubsc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_word(in_data), .out_fire, .sts, .cmd, .busy, .out_valid
  );

  ubsc_datapath u_dp (
    .clk, .rst, .cmd, .in_word(in_data), .sts, .result(out_data)
  );

endmodule

[rtl/ubsc_datapath.sv]
// Lookahead window, head decision logic, name lookup and the ten tallies.
// Depends on ubsc_pkg.
module ubsc_datapath
  import ubsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_word,
  output dp_sts_t   sts,
  output out_word_t result
);

  logic [7:0]  win [WinDepth];
  logic [2:0]  fill;
  logic [31:0] tally [10];

  // Head decision.
  logic [2:0]  adv;        // bytes consumed
  logic        decide;
  logic [9:0]  inc;        // one-hot-ish increments
  logic [2:0]  pb_add;
  logic [2:0]  close_d;
  logic        close_found;
  logic [47:0] name;
  logic        known;
  logic        is_plain_print;

  always_comb begin
    close_found = 1'b0;
    close_d = '0;
    for (int d = WinDepth - 1; d >= 1; d--) begin
      if (3'(d) < fill && win[d] == 8'h5D) begin
        close_found = 1'b1;
        close_d = 3'(d);
      end
    end
  end

  // Name bytes 1..close_d-1 cut at first zero.
  always_comb begin
    logic cut;
    cut = 1'b0;
    name = '0;
    for (int j = 0; j < MaxSpan - 1; j++) begin
      if (3'(j + 1) < close_d && !cut && win[j + 1] != 8'h00)
        name[j*8 +: 8] = win[j + 1];
      else
        cut = 1'b1;
    end
  end

  always_comb begin
    known = 1'b0;
    for (int k = 0; k < TableSize; k++)
      if (name != '0 && name == name_entry(6'(k))) known = 1'b1;
  end

  assign is_plain_print = (win[0] >= 8'h20) && (win[0] <= 8'h7E);

  always_comb begin
    decide = 1'b0;
    adv = 3'd1;
    inc = '0;
    pb_add = '0;
    if (fill != '0) begin
      decide = 1'b1;
      priority if (win[0] == 8'h0A) begin
        inc[T_LF] = 1'b1;
      end else if (win[0] == 8'h0D) begin
        inc[T_CR] = 1'b1;
      end else if (win[0] == 8'h3C) begin
        if (fill > 3'd2) begin
          if (win[1] == 8'h4F && win[2] == 8'h4B) begin
            inc[T_OK] = 1'b1;
            adv = 3'd3;
          end else begin
            inc[T_PRINT] = 1'b1;
          end
        end else if (cmd.flush) begin
          inc[T_PRINT] = 1'b1;
        end else begin
          decide = 1'b0;
        end
      end else if (win[0] == 8'h5B) begin
        if (close_found) begin
          if (known) begin
            inc[T_PORT] = 1'b1;
            pb_add = close_d + 3'd1;
            adv = close_d + 3'd1;
          end else begin
            inc[T_BADPORT] = 1'b1;
            inc[T_PRINT] = 1'b1;
          end
        end else if (cmd.flush || fill == 3'(WinDepth)) begin
          inc[T_PRINT] = 1'b1;
        end else begin
          decide = 1'b0;
        end
      end else if (is_plain_print) begin
        inc[T_PRINT] = 1'b1;
      end else begin
        inc[T_BIN] = 1'b1;
      end
    end
  end

  assign sts.can_step = decide;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      for (int t = 0; t < 10; t++) tally[t] <= '0;
    end else if (cmd.load) begin
      unique case (in_word.op)
        OP_DATA: begin
          if (fill < 3'(WinDepth)) begin
            win[fill] <= in_word.data_byte;
            fill <= fill + 3'd1;
          end
        end
        OP_BADASC: tally[T_BADASC] <= tally[T_BADASC] + 32'd1;
        OP_BADBIN: tally[T_BADBIN] <= tally[T_BADBIN] + 32'd1;
        default: ;
      endcase
    end else if (cmd.step && decide) begin
      for (int t = 0; t < 8; t++)
        if (inc[t]) tally[t] <= tally[t] + 32'd1;
      if (inc[T_PORT]) tally[T_PBYTES] <= tally[T_PBYTES] + 32'(pb_add);
      for (int s = 0; s < WinDepth; s++)
        if (s + int'(adv) < WinDepth) win[s] <= win[s + int'(adv)];
      fill <= fill - adv;
    end
  end

  assign result.printable_bytes     = tally[T_PRINT];
  assign result.binary_bytes        = tally[T_BIN];
  assign result.line_feeds          = tally[T_LF];
  assign result.carriage_returns    = tally[T_CR];
  assign result.ok_prompts          = tally[T_OK];
  assign result.port_prompts        = tally[T_PORT];
  assign result.bad_port_prompts    = tally[T_BADPORT];
  assign result.port_prompt_bytes   = tally[T_PBYTES];
  assign result.bad_ascii_messages  = tally[T_BADASC];
  assign result.bad_binary_messages = tally[T_BADBIN];
  assign result.pending_bytes       = fill;

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= 3'(WinDepth)) else $error("window overfilled");
  a_adv_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && decide) |-> adv <= fill) else $error("advance past fill");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> fill == '0 && tally[T_PRINT] == '0) else $error("clear missed");

endmodule

[rtl/ubsc_ctrl.sv]
// Sequencer: accepts a word, drains the window one decision per cycle for a data
// or flush word, then presents the result. Depends on ubsc_pkg.
module ubsc_ctrl
  import ubsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  in_word_t in_word,
  input  logic     out_fire,
  input  dp_sts_t  sts,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_valid
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_SHOW  = 2'd2;

  logic [1:0] state, state_next;
  logic       flush;
  logic       flush_next;

  always_comb begin
    state_next = state;
    flush_next = flush;
    cmd = '0;
    cmd.flush = flush;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          cmd.clear = (in_word.op == OP_CLEAR);
          flush_next = (in_word.op == OP_FLUSH);
          state_next = (in_word.op == OP_DATA || in_word.op == OP_FLUSH) ? S_DRAIN : S_SHOW;
        end
      end
      S_DRAIN: begin
        cmd.step = 1'b1;
        if (!sts.can_step) state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      flush <= flush_next;
    end
  end

  assign busy      = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load while busy");
  a_show_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && !out_fire) |=> state == S_SHOW) else $error("result dropped");
  a_step_only_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !out_valid) else $error("step while showing");

endmodule

[tb/testbench.sv]
// Testbench for unknown_byte_stream_classifier: random and directed byte streams,
// checked word by word against a behavioral tally model. Depends on ubsc_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ubsc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  unknown_byte_stream_classifier dut (.*);

  always #10 clk = ~clk;

  // classifier state mirror
  logic [7:0]  win [WinDepth];
  int          fill;
  logic [31:0] tally [10];
  out_word_t   tally_queue [$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          hold_off = 0;
  int          burst_left = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void count_plain(input logic [7:0] b);
    if (b >= 8'h20 && b <= 8'h7e) tally[T_PRINT]++;
    else tally[T_BIN]++;
  endfunction

  function automatic bit port_known(input int base, input int len);
    string names [42] = '{"COM1","COM2","COM3","COM4","COM5","COM6","COM7","COM8",
      "COM9","COM10","CCOM1","CCOM2","CCOM3","CCOM4","CCOM5","CCOM6","CCOM7",
      "CCOM8","ICOM1","ICOM2","ICOM3","ICOM4","ICOM5","ICOM6","ICOM7","SCOM1",
      "SCOM2","SCOM3","SCOM4","NCOM1","NCOM2","NCOM3","USB1","USB2","USB3",
      "XCOM1","XCOM2","XCOM3","ACK","FILE","AUX","WCOM1"};
    bit same;
    if (len == 0) return 1'b0;
    foreach (names[k]) begin
      if (names[k].len() != len) continue;
      same = 1'b1;
      for (int j = 0; j < len; j++)
        if (names[k][j] != win[base + j]) same = 1'b0;
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drain_window(input bit flush);
    int i, left, d, len;
    bit found, stop;
    i = 0;
    stop = 1'b0;
    while (i < fill && !stop) begin
      left = fill - i;
      if (win[i] == 8'h0a) tally[T_LF]++;
      else if (win[i] == 8'h0d) tally[T_CR]++;
      else if (win[i] == "<") begin
        if (left > 2) begin
          if (win[i+1] == "O" && win[i+2] == "K") begin
            tally[T_OK]++;
            i += 2;
          end else count_plain(win[i]);
        end else if (flush) count_plain(win[i]);
        else stop = 1'b1;
      end else if (win[i] == "[") begin
        found = 1'b0;
        for (d = 1; d < left; d++)
          if (win[i+d] == "]") begin
            found = 1'b1;
            break;
          end
        if (found) begin
          if (d <= MaxSpan) begin
            len = 0;
            while (len < d - 1 && win[i+1+len] != 8'h00) len++;
            if (port_known(i + 1, len)) begin
              tally[T_PORT]++;
              tally[T_PBYTES] += 32'(d + 1);
              i += d;
            end else begin
              tally[T_BADPORT]++;
              count_plain(win[i]);
            end
          end else count_plain(win[i]);
        end else if (flush || left >= WinDepth) count_plain(win[i]);
        else stop = 1'b1;
      end else count_plain(win[i]);
      if (!stop) i++;
    end
    if (i > fill) i = fill;
    for (int k = 0; k + i < fill; k++) win[k] = win[k+i];
    fill -= i;
  endfunction

  function automatic out_word_t classify(input in_word_t w);
    out_word_t r;
    case (w.op)
      OP_DATA: begin
        if (fill < WinDepth) begin
          win[fill] = w.data_byte;
          fill++;
        end
        drain_window(1'b0);
      end
      OP_FLUSH:  drain_window(1'b1);
      OP_BADASC: tally[T_BADASC]++;
      OP_BADBIN: tally[T_BADBIN]++;
      OP_CLEAR: begin
        fill = 0;
        foreach (tally[k]) tally[k] = '0;
      end
      default: ;
    endcase
    r.printable_bytes     = tally[T_PRINT];
    r.binary_bytes        = tally[T_BIN];
    r.line_feeds          = tally[T_LF];
    r.carriage_returns    = tally[T_CR];
    r.ok_prompts          = tally[T_OK];
    r.port_prompts        = tally[T_PORT];
    r.bad_port_prompts    = tally[T_BADPORT];
    r.port_prompt_bytes   = tally[T_PBYTES];
    r.bad_ascii_messages  = tally[T_BADASC];
    r.bad_binary_messages = tally[T_BADBIN];
    r.pending_bytes       = fill[2:0];
    return r;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, data_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally_queue = {tally_queue, classify('{op: op, data_byte: b})};
  endtask

  task automatic send_text(input string s);
    foreach (s[k]) send_word(OP_DATA, s[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tally_queue.size() != 0) @(posedge clk);
  endtask

  // receiver stall: random bursts, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else if (burst_left > 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 4);
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tally_queue.size() == 0) begin
        report("unexpected result word", '0, '0);
      end else begin
        want = tally_queue.pop_front();
        if (out_data.printable_bytes != want.printable_bytes)
          report("printable_bytes", out_data.printable_bytes, want.printable_bytes);
        if (out_data.binary_bytes != want.binary_bytes)
          report("binary_bytes", out_data.binary_bytes, want.binary_bytes);
        if (out_data.line_feeds != want.line_feeds)
          report("line_feeds", out_data.line_feeds, want.line_feeds);
        if (out_data.carriage_returns != want.carriage_returns)
          report("carriage_returns", out_data.carriage_returns, want.carriage_returns);
        if (out_data.ok_prompts != want.ok_prompts)
          report("ok_prompts", out_data.ok_prompts, want.ok_prompts);
        if (out_data.port_prompts != want.port_prompts)
          report("port_prompts", out_data.port_prompts, want.port_prompts);
        if (out_data.bad_port_prompts != want.bad_port_prompts)
          report("bad_port_prompts", out_data.bad_port_prompts, want.bad_port_prompts);
        if (out_data.port_prompt_bytes != want.port_prompt_bytes)
          report("port_prompt_bytes", out_data.port_prompt_bytes, want.port_prompt_bytes);
        if (out_data.bad_ascii_messages != want.bad_ascii_messages)
          report("bad_ascii_messages", out_data.bad_ascii_messages,
                 want.bad_ascii_messages);
        if (out_data.bad_binary_messages != want.bad_binary_messages)
          report("bad_binary_messages", out_data.bad_binary_messages,
                 want.bad_binary_messages);
        if (out_data.pending_bytes != want.pending_bytes)
          report("pending_bytes", 32'(out_data.pending_bytes), 32'(want.pending_bytes));
      end
    end
  end

  task automatic test_directed();
    send_word(OP_DATA, 8'h0a);
    send_word(OP_DATA, 8'h0d);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'hff);
    send_word(OP_DATA, 8'h7e);
    send_text("<OK");
    send_text("[COM10]");
    send_text("[XYZ]");
    send_text("[]");
    send_text("[ABCDEFG]");
    send_word(OP_DATA, "[");
    send_word(OP_DATA, "A");
    send_word(OP_DATA, "C");
    send_word(OP_DATA, "K");
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, "]");
    send_text("[US");
    send_word(OP_FLUSH, 8'h00);
    send_word(OP_DATA, "<");
    send_word(OP_FLUSH, 8'hff);
    send_word(OP_BADASC, 8'h00);
    send_word(OP_BADBIN, 8'h00);
    send_word(3'd5, 8'h00);
    send_word(3'd7, 8'h00);
    send_word(OP_CLEAR, 8'h00);
  endtask

  // a mix of prompts with names from a short list, plus noise and random ops
  task automatic test_random_stream();
    string names [8] = '{"COM1", "COM10", "CCOM1", "USB1", "ACK", "WCOM1", "COMX", "AB"};
    string s;
    int n;
    int zpos;
    n = 0;
    while (n < 440) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          s = {"[", names[$urandom_range(0, 7)], "]"};
          // put a zero byte somewhere after the open bracket now and then
          zpos = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, s.len() - 1)) : -1;
          foreach (s[k]) send_word(OP_DATA, (k == zpos) ? 8'h00 : 8'(s[k]));
          n += s.len();
        end
        2: begin
          send_text("<OK");
          n += 3;
        end
        3: begin
          send_word(OP_DATA, $urandom_range(0, 1) ? "<" : "[");
          n++;
        end
        4: begin
          send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          n++;
        end
        default: begin
          send_word(OP_DATA, 8'($urandom_range(0, 255)));
          n++;
        end
      endcase
    end
    send_word(OP_FLUSH, 8'h00);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_off <= 200;
    for (int k = 0; k < 20; k++) send_word(OP_DATA, 8'($urandom_range(32, 126)));
    wait_drained();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    for (int k = 0; k < 40; k++) send_word(OP_DATA, 8'($urandom_range(0, 255)));
    send_text("[AUX]");
    send_word(OP_FLUSH, 8'h00);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fill = 0;
    foreach (tally[k]) tally[k] = '0;
    test_directed();
    wait_drained();
    test_backpressure();
    test_random_stream();
    test_quiet_tail();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("** unknown_byte_stream_classifier: PASSED **");
    else $display("** unknown_byte_stream_classifier: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** unknown_byte_stream_classifier: FAILED **");
    $finish;
  end
endmodule
